// File: src/assr_pkg.sv
// shared types, constants and helpers for the annular sector span rasterizer
// depends on nothing; imported by annular_sector_span_raster, span_checker and tb
package assr_pkg;

	localparam int COORD_BITS     = 12;
	localparam int EXT_BITS       = COORD_BITS + 2;
	localparam int RAD_BITS       = 9;
	localparam int POS_BITS       = 11;
	localparam int SLOPE_BITS     = 24;
	localparam int DIM_BITS       = 12;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_DISPLAY_WIDTH  = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_DISPLAY_HEIGHT = CFG_INDEX_BITS'(1);

	localparam logic [1:0] QUAD_UPPER_RIGHT = 2'd0;
	localparam logic [1:0] QUAD_LOWER_RIGHT = 2'd1;
	localparam logic [1:0] QUAD_LOWER_LEFT  = 2'd2;
	localparam logic [1:0] QUAD_UPPER_LEFT  = 2'd3;

	localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(400);
	localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(300);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [EXT_BITS-1:0]   ext_t;

	localparam ext_t COORD_MAX_EXT = ext_t'((1 << (COORD_BITS - 1)) - 1);
	localparam ext_t COORD_MIN_EXT = ext_t'(-(1 << (COORD_BITS - 1)));

	localparam coord_t BOX_LEFT_RESET = coord_t'(WIDTH_RESET - DIM_BITS'(1));
	localparam coord_t BOX_TOP_RESET  = coord_t'(HEIGHT_RESET - DIM_BITS'(1));

	typedef struct packed {
		logic [1:0]            quadrant;
		logic [POS_BITS-1:0]   center_x;
		logic [POS_BITS-1:0]   center_y;
		logic [RAD_BITS-1:0]   inner_radius;
		logic [RAD_BITS-1:0]   outer_radius;
		logic [SLOPE_BITS-1:0] slope_start;
		logic [SLOPE_BITS-1:0] slope_end;
		logic [RAD_BITS-1:0]   row_offset;
		logic                  measure_only;
		logic                  clear_box;
	} row_word_t;

	typedef struct packed {
		logic   span_valid;
		coord_t span_left;
		coord_t span_right;
		coord_t span_row;
		coord_t box_left;
		coord_t box_top;
		coord_t box_right;
		coord_t box_bottom;
	} span_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OFFSQ,
		ST_RISQ,
		ST_ROSQ,
		ST_PS,
		ST_PE,
		ST_PEW,
		ST_ROOT_I,
		ST_ROOT_O,
		ST_CLIP,
		ST_FIN
	} seq_state_t;

	function automatic coord_t sat_coord(input ext_t v);
		coord_t r;
		if (v > COORD_MAX_EXT) begin
			r = COORD_MAX_EXT[COORD_BITS-1:0];
		end else if (v < COORD_MIN_EXT) begin
			r = COORD_MIN_EXT[COORD_BITS-1:0];
		end else begin
			r = v[COORD_BITS-1:0];
		end
		return r;
	endfunction

endpackage

// File: src/annular_sector_span_raster.sv
// row words are taken one at a time, only in the idle state; each makes five
// passes through the shared 24x9 multiplier, then two 9-step passes through the
// shared square root unit, before its result word is loaded
// the result sits in an output register, so the next row is taken while it waits
// reset: width 400, height 300, box 399/299/0/0; no clearing pass
// depends on assr_pkg
module annular_sector_span_raster #(
	parameter int MAX_RADIUS      = 511,
	parameter int SLOPE_FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [assr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [assr_pkg::DIM_BITS-1:0]         cfg_data,
	input  logic                                  row_valid,
	output logic                                  row_stall,
	input  assr_pkg::row_word_t                   row,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output assr_pkg::span_word_t                  res
);
	import assr_pkg::*;

	localparam int PROD_BITS = SLOPE_BITS + RAD_BITS;
	localparam int SQ_BITS   = 2 * RAD_BITS;
	localparam int STEP_BITS = $clog2(RAD_BITS);
	localparam int RCMP_BITS = RAD_BITS + 3;
	localparam logic [STEP_BITS-1:0] LAST_STEP  = STEP_BITS'(RAD_BITS - 1);
	localparam logic [RCMP_BITS-1:0] MAX_R      = RCMP_BITS'(MAX_RADIUS);
	localparam logic [PROD_BITS-1:0] CMAX_PROD  = PROD_BITS'((1 << (COORD_BITS - 1)) - 1);
	localparam logic [SQ_BITS-2:0]   ROOT_BIT0  = (SQ_BITS-1)'(1) << (SQ_BITS - 2);

	seq_state_t state_q, state_d;

	logic [DIM_BITS-1:0] width_q, height_q;
	coord_t min_col_q, min_row_q, max_col_q, max_row_q;

	logic [1:0]            quad_q;
	logic [POS_BITS-1:0]   cx_q, cy_q;
	logic [RAD_BITS-1:0]   ri_q, ro_q, off_q;
	logic [SLOPE_BITS-1:0] ss_q, se_q;
	logic                  measure_q;

	logic [PROD_BITS-1:0] prod_q;
	logic [SQ_BITS-1:0]   offsq_q, rad_i_q, rad_o_q;
	coord_t               ps_q, pe_q;
	ext_t                 ci_q, co_q;

	logic [SQ_BITS-1:0]   root_x_q, root_acc_q;
	logic [SQ_BITS-2:0]   root_bit_q;
	logic [STEP_BITS-1:0] step_q;

	logic       res_valid_q;
	span_word_t word_q;

	logic                  accept, fin_load, out_free;
	logic [SLOPE_BITS-1:0] mul_a;
	logic [RAD_BITS-1:0]   mul_b;

	function automatic logic [RAD_BITS-1:0] clamp_radius(input logic [RAD_BITS-1:0] r);
		logic [RAD_BITS-1:0] v;
		if (RCMP_BITS'(r) > MAX_R) begin
			v = MAX_R[RAD_BITS-1:0];
		end else begin
			v = r;
		end
		return v;
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (row_valid) state_d = ST_OFFSQ;
			ST_OFFSQ:  state_d = ST_RISQ;
			ST_RISQ:   state_d = ST_ROSQ;
			ST_ROSQ:   state_d = ST_PS;
			ST_PS:     state_d = ST_PE;
			ST_PE:     state_d = ST_PEW;
			ST_PEW:    state_d = ST_ROOT_I;
			ST_ROOT_I: if (step_q == LAST_STEP) state_d = ST_ROOT_O;
			ST_ROOT_O: if (step_q == LAST_STEP) state_d = ST_CLIP;
			ST_CLIP:   state_d = ST_FIN;
			ST_FIN:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		row_stall = (state_q != ST_IDLE);
		accept    = row_valid && (state_q == ST_IDLE);
		out_free  = !res_valid_q || !res_stall;
		fin_load  = (state_q == ST_FIN) && out_free;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_OFFSQ: begin
				mul_a = SLOPE_BITS'(off_q);
				mul_b = off_q;
			end
			ST_RISQ: begin
				mul_a = SLOPE_BITS'(ri_q);
				mul_b = ri_q;
			end
			ST_ROSQ: begin
				mul_a = SLOPE_BITS'(ro_q);
				mul_b = ro_q;
			end
			ST_PS: begin
				mul_a = ss_q;
				mul_b = off_q;
			end
			ST_PE: begin
				mul_a = se_q;
				mul_b = off_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// one restoring square root step
	logic [SQ_BITS:0]    trial;
	logic [SQ_BITS-1:0]  nx, nacc;
	logic [RAD_BITS-1:0] root;
	logic [RAD_BITS:0]   rounded;
	ext_t                root_ext;

	always_comb begin
		trial = {1'b0, root_acc_q} + {2'b00, root_bit_q};
		if ({1'b0, root_x_q} >= trial) begin
			nx   = root_x_q - trial[SQ_BITS-1:0];
			nacc = (root_acc_q >> 1) + {1'b0, root_bit_q};
		end else begin
			nx   = root_x_q;
			nacc = root_acc_q >> 1;
		end
		root     = nacc[RAD_BITS-1:0];
		rounded  = {1'b0, root} + {{RAD_BITS{1'b0}}, (nx > SQ_BITS'(root))};
		root_ext = {{(EXT_BITS-RAD_BITS-1){1'b0}}, rounded};
	end

	// slope product, truncated and saturated
	logic [PROD_BITS-1:0] shifted;
	coord_t               clip_val;

	always_comb begin
		shifted  = prod_q >> SLOPE_FRAC_BITS;
		clip_val = (shifted > CMAX_PROD) ? CMAX_PROD[COORD_BITS-1:0]
		                                 : shifted[COORD_BITS-1:0];
	end

	// boundary clipping
	ext_t ps_e, pe_e, ci_clip, co_clip;

	always_comb begin
		ps_e = {{(EXT_BITS-COORD_BITS){1'b0}}, ps_q};
		pe_e = {{(EXT_BITS-COORD_BITS){1'b0}}, pe_q};
		if (quad_q == QUAD_UPPER_RIGHT || quad_q == QUAD_LOWER_LEFT) begin
			ci_clip = (ps_e > ci_q) ? ps_e : ci_q;
			co_clip = (pe_e < co_q) ? pe_e : co_q;
		end else begin
			co_clip = (ps_e < co_q) ? ps_e : co_q;
			ci_clip = (pe_e > ci_q) ? pe_e : ci_q;
		end
	end

	// span and box update
	logic       have;
	ext_t       cx_e, cy_e, off_e, left_e, right_e, row_e;
	coord_t     left_c, right_c, row_c;
	coord_t     min_col_d, min_row_d, max_col_d, max_row_d;
	span_word_t word_d;

	always_comb begin
		have  = (off_q <= ro_q) && (ci_q <= co_q);
		cx_e  = {{(EXT_BITS-POS_BITS){1'b0}}, cx_q};
		cy_e  = {{(EXT_BITS-POS_BITS){1'b0}}, cy_q};
		off_e = {{(EXT_BITS-RAD_BITS){1'b0}}, off_q};
		if (quad_q == QUAD_UPPER_RIGHT || quad_q == QUAD_UPPER_LEFT) begin
			row_e = cy_e - off_e;
		end else begin
			row_e = cy_e + off_e;
		end
		if (quad_q == QUAD_UPPER_RIGHT || quad_q == QUAD_LOWER_RIGHT) begin
			left_e  = cx_e + ci_q;
			right_e = cx_e + co_q;
		end else begin
			left_e  = cx_e - co_q;
			right_e = cx_e - ci_q;
		end
		left_c  = sat_coord(left_e);
		right_c = sat_coord(right_e);
		row_c   = sat_coord(row_e);

		min_col_d = min_col_q;
		min_row_d = min_row_q;
		max_col_d = max_col_q;
		max_row_d = max_row_q;
		if (have && measure_q) begin
			if (left_c < min_col_q) min_col_d = left_c;
			if (row_c < min_row_q) min_row_d = row_c;
			if (right_c > max_col_q) max_col_d = right_c;
			if (row_c > max_row_q) max_row_d = row_c;
		end

		word_d.span_valid = have && !measure_q;
		word_d.span_left  = word_d.span_valid ? left_c : '0;
		word_d.span_right = word_d.span_valid ? right_c : '0;
		word_d.span_row   = word_d.span_valid ? row_c : '0;
		word_d.box_left   = min_col_d;
		word_d.box_top    = min_row_d;
		word_d.box_right  = max_col_d;
		word_d.box_bottom = max_row_d;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DISPLAY_WIDTH:  width_q <= cfg_data;
				REG_DISPLAY_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// bounding box
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_col_q <= BOX_LEFT_RESET;
			min_row_q <= BOX_TOP_RESET;
			max_col_q <= '0;
			max_row_q <= '0;
		end else if (accept && row.clear_box) begin
			min_col_q <= sat_coord({{(EXT_BITS-DIM_BITS){1'b0}}, width_q} - ext_t'(1));
			min_row_q <= sat_coord({{(EXT_BITS-DIM_BITS){1'b0}}, height_q} - ext_t'(1));
			max_col_q <= '0;
			max_row_q <= '0;
		end else if (fin_load) begin
			min_col_q <= min_col_d;
			min_row_q <= min_row_d;
			max_col_q <= max_col_d;
			max_row_q <= max_row_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			quad_q    <= row.quadrant;
			cx_q      <= row.center_x;
			cy_q      <= row.center_y;
			ri_q      <= clamp_radius(row.inner_radius);
			ro_q      <= clamp_radius(row.outer_radius);
			off_q     <= clamp_radius(row.row_offset);
			ss_q      <= row.slope_start;
			se_q      <= row.slope_end;
			measure_q <= row.measure_only;
		end
		prod_q <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
		case (state_q)
			ST_RISQ: offsq_q <= prod_q[SQ_BITS-1:0];
			ST_ROSQ: rad_i_q <= prod_q[SQ_BITS-1:0] - offsq_q;
			ST_PS:   rad_o_q <= prod_q[SQ_BITS-1:0] - offsq_q;
			ST_PE:   ps_q <= clip_val;
			ST_PEW: begin
				pe_q       <= clip_val;
				root_x_q   <= rad_i_q;
				root_acc_q <= '0;
				root_bit_q <= ROOT_BIT0;
				step_q     <= '0;
			end
			ST_ROOT_I: begin
				if (step_q == LAST_STEP) begin
					ci_q       <= (ri_q < off_q) ? ext_t'(-1) : root_ext;
					root_x_q   <= rad_o_q;
					root_acc_q <= '0;
					root_bit_q <= ROOT_BIT0;
					step_q     <= '0;
				end else begin
					root_x_q   <= nx;
					root_acc_q <= nacc;
					root_bit_q <= root_bit_q >> 2;
					step_q     <= step_q + STEP_BITS'(1);
				end
			end
			ST_ROOT_O: begin
				root_x_q   <= nx;
				root_acc_q <= nacc;
				root_bit_q <= root_bit_q >> 2;
				step_q     <= step_q + STEP_BITS'(1);
				if (step_q == LAST_STEP) co_q <= root_ext;
			end
			ST_CLIP: begin
				ci_q <= ci_clip;
				co_q <= co_clip;
			end
			default: ;
		endcase
		if (fin_load) word_q <= word_d;
	end

	assign res_valid = res_valid_q;
	assign res       = word_q;

endmodule

// File: dv/span_checker.sv
// span checker: predicts the span word of every accepted row word and compares it
// with the span words the rasterizer hands out; tracks display size and bounding box
// depends on assr_pkg
`timescale 1ns / 1ps

module span_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [assr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [assr_pkg::DIM_BITS-1:0]       cfg_data,
	input  logic                                row_valid,
	input  logic                                row_stall,
	input  assr_pkg::row_word_t                 row,
	input  logic                                res_valid,
	input  logic                                res_stall,
	input  assr_pkg::span_word_t                res,
	output int                                  fails,
	output int                                  pending
);
	import assr_pkg::*;

	localparam int RADIUS_CAP = 511;
	localparam int FRAC_BITS  = 16;
	localparam int COORD_HI   = (1 << (COORD_BITS - 1)) - 1;
	localparam int COORD_LO   = -(1 << (COORD_BITS - 1));

	logic [DIM_BITS-1:0] disp_w;
	logic [DIM_BITS-1:0] disp_h;
	int                  min_col;
	int                  min_row;
	int                  max_col;
	int                  max_row;
	span_word_t          expected_spans[$];
	span_word_t          want;

	function automatic int clamp_coord(input int v);
		if (v > COORD_HI) begin
			return COORD_HI;
		end
		if (v < COORD_LO) begin
			return COORD_LO;
		end
		return v;
	endfunction

	function automatic int cap_radius(input logic [RAD_BITS-1:0] v);
		return (int'(v) > RADIUS_CAP) ? RADIUS_CAP : int'(v);
	endfunction

	// nearest integer root, halves rounded up
	function automatic int root_round(input int x);
		int r;
		int t;
		r = 0;
		for (int b = 9; b >= 0; b--) begin
			t = r | (1 << b);
			if (t * t <= x) begin
				r = t;
			end
		end
		if (x - r * r > r) begin
			r++;
		end
		return r;
	endfunction

	function automatic int boundary_reach(input logic [SLOPE_BITS-1:0] slope, input int off);
		longint unsigned s;
		longint unsigned m;
		longint unsigned p;
		s = 64'(slope);
		m = 64'(off);
		p = (s * m) >> FRAC_BITS;
		return (p > COORD_HI) ? COORD_HI : int'(p);
	endfunction

	function automatic void reset_box();
		min_col = clamp_coord(int'(disp_w) - 1);
		min_row = clamp_coord(int'(disp_h) - 1);
		max_col = 0;
		max_row = 0;
	endfunction

	function automatic span_word_t raster_row(input row_word_t w);
		span_word_t o;
		int ri;
		int ro;
		int off;
		int ci;
		int co;
		int ps;
		int pe;
		int left;
		int right;
		int y;
		bit hit;
		ri = cap_radius(w.inner_radius);
		ro = cap_radius(w.outer_radius);
		off = cap_radius(w.row_offset);
		hit = 1'b0;
		left = 0;
		right = 0;
		y = 0;
		if (w.clear_box) begin
			reset_box();
		end
		if (off <= ro) begin
			ci = (ri < off) ? -1 : root_round(ri * ri - off * off);
			co = root_round(ro * ro - off * off);
			ps = boundary_reach(w.slope_start, off);
			pe = boundary_reach(w.slope_end, off);
			if (w.quadrant == QUAD_UPPER_RIGHT || w.quadrant == QUAD_LOWER_LEFT) begin
				if (ps > ci) ci = ps;
				if (pe < co) co = pe;
			end else begin
				if (ps < co) co = ps;
				if (pe > ci) ci = pe;
			end
			if (ci <= co) begin
				hit = 1'b1;
				if (w.quadrant == QUAD_UPPER_RIGHT || w.quadrant == QUAD_UPPER_LEFT) begin
					y = int'(w.center_y) - off;
				end else begin
					y = int'(w.center_y) + off;
				end
				if (w.quadrant == QUAD_UPPER_RIGHT || w.quadrant == QUAD_LOWER_RIGHT) begin
					left = int'(w.center_x) + ci;
					right = int'(w.center_x) + co;
				end else begin
					left = int'(w.center_x) - co;
					right = int'(w.center_x) - ci;
				end
				left = clamp_coord(left);
				right = clamp_coord(right);
				y = clamp_coord(y);
			end
		end
		if (hit && w.measure_only) begin
			if (left < min_col) min_col = left;
			if (y < min_row) min_row = y;
			if (right > max_col) max_col = right;
			if (y > max_row) max_row = y;
		end
		o.span_valid = hit && !w.measure_only;
		if (!o.span_valid) begin
			left = 0;
			right = 0;
			y = 0;
		end
		o.span_left = coord_t'(left);
		o.span_right = coord_t'(right);
		o.span_row = coord_t'(y);
		o.box_left = coord_t'(min_col);
		o.box_top = coord_t'(min_row);
		o.box_right = coord_t'(max_col);
		o.box_bottom = coord_t'(max_row);
		return o;
	endfunction

	task automatic check_field(input string name, input integer exp_v, input integer act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_w = WIDTH_RESET;
			disp_h = HEIGHT_RESET;
			reset_box();
			expected_spans.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_spans.size() == 0) begin
					$error("span word with nothing expected");
					fails++;
				end else begin
					want = expected_spans.pop_front();
					check_field("span_valid", want.span_valid, res.span_valid);
					check_field("span_left", want.span_left, res.span_left);
					check_field("span_right", want.span_right, res.span_right);
					check_field("span_row", want.span_row, res.span_row);
					check_field("box_left", want.box_left, res.box_left);
					check_field("box_top", want.box_top, res.box_top);
					check_field("box_right", want.box_right, res.box_right);
					check_field("box_bottom", want.box_bottom, res.box_bottom);
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_DISPLAY_WIDTH) begin
					disp_w = cfg_data;
				end else if (cfg_index == REG_DISPLAY_HEIGHT) begin
					disp_h = cfg_data;
				end
			end
			if (row_valid && !row_stall) begin
				expected_spans.push_back(raster_row(row));
			end
			pending = expected_spans.size();
		end
	end

endmodule

// File: dv/tb.sv
// top of the rasterizer testbench: clock, reset, row word and register stimulus
// with random idling on both channels; verdict from span_checker
// depends on assr_pkg, annular_sector_span_raster and span_checker
`timescale 1ns / 1ps

module tb;
	import assr_pkg::*;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = CFG_INDEX_BITS'(2);
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = CFG_INDEX_BITS'(3);
	localparam logic [SLOPE_BITS-1:0]     SLOPE_FULL  = '1;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [DIM_BITS-1:0]       cfg_data;
	logic                      row_valid;
	logic                      row_stall;
	row_word_t                 row;
	logic                      res_valid;
	logic                      res_stall;
	span_word_t                res;
	int                        fails;
	int                        pending;
	int                        idle_pct = 0;
	int                        hold_cycles = 0;
	int                        sent = 0;

	annular_sector_span_raster dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.row_valid(row_valid),
		.row_stall(row_stall),
		.row(row),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	span_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.row_valid(row_valid),
		.row_stall(row_stall),
		.row(row),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.fails(fails),
		.pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// span word receiver: random stall bursts plus a single long hold-off
	initial begin
		int burst;
		burst = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				res_stall <= 1'b1;
				hold_cycles--;
			end else if (burst > 0) begin
				res_stall <= 1'b1;
				burst--;
			end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
				res_stall <= 1'b1;
				burst = $urandom_range(5);
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	task automatic offer(input row_word_t w);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			repeat ($urandom_range(1, 6)) begin
				@(negedge clk);
				row_valid <= 1'b0;
			end
		end
		@(negedge clk);
		row <= w;
		row_valid <= 1'b1;
		@(posedge clk);
		while (row_stall) @(posedge clk);
		sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		row_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [DIM_BITS-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_dims(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
		write_reg(REG_DISPLAY_WIDTH, w);
		write_reg(REG_DISPLAY_HEIGHT, h);
	endtask

	function automatic row_word_t make_row(input logic [1:0] q, input int cx, input int cy,
			input int ri, input int ro, input logic [SLOPE_BITS-1:0] ss,
			input logic [SLOPE_BITS-1:0] se, input int off, input bit meas, input bit clr);
		row_word_t w;
		w.quadrant = q;
		w.center_x = POS_BITS'(cx);
		w.center_y = POS_BITS'(cy);
		w.inner_radius = RAD_BITS'(ri);
		w.outer_radius = RAD_BITS'(ro);
		w.slope_start = ss;
		w.slope_end = se;
		w.row_offset = RAD_BITS'(off);
		w.measure_only = meas;
		w.clear_box = clr;
		return w;
	endfunction

	function automatic row_word_t noise_row();
		logic [127:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom};
		return bits[$bits(row_word_t)-1:0];
	endfunction

	function automatic logic [SLOPE_BITS-1:0] gentle_slope();
		if ($urandom_range(6) == 0) begin
			return SLOPE_BITS'($urandom);
		end
		return SLOPE_BITS'($urandom_range(0, 'h1_0000));
	endfunction

	function automatic logic [SLOPE_BITS-1:0] steep_slope();
		case ($urandom_range(6))
			0: return SLOPE_FULL;
			1: return SLOPE_BITS'($urandom);
			default: return SLOPE_BITS'($urandom_range('h1_0000, 'h40_0000));
		endcase
	endfunction

	// one quarter-annulus sector scanned at every stride-th row offset from the centre outwards
	task automatic sweep_sector();
		row_word_t w;
		int ro;
		int stride;
		w.quadrant = 2'($urandom_range(3));
		w.center_x = POS_BITS'($urandom_range(2047));
		w.center_y = POS_BITS'($urandom_range(2047));
		ro = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(40);
		w.outer_radius = RAD_BITS'(ro);
		w.inner_radius = ($urandom_range(9) == 0) ? RAD_BITS'($urandom) :
			RAD_BITS'($urandom_range(ro));
		if (w.quadrant == QUAD_UPPER_RIGHT || w.quadrant == QUAD_LOWER_LEFT) begin
			w.slope_start = gentle_slope();
			w.slope_end = steep_slope();
		end else begin
			w.slope_start = steep_slope();
			w.slope_end = gentle_slope();
		end
		w.measure_only = 1'($urandom_range(1));
		stride = ro / 24 + 1;
		for (int r = 0; r <= ro; r += stride) begin
			w.row_offset = RAD_BITS'(r);
			if (r == 0) begin
				w.clear_box = w.measure_only && ($urandom_range(1) == 1);
			end else begin
				w.clear_box = ($urandom_range(19) == 0);
			end
			offer(w);
		end
	endtask

	initial begin
		int widths[5];
		int heights[5];
		int idles[5];
		int goal;
		bit held;
		bit paused;
		widths = '{1, 2048, 4095, 0, 400};
		heights = '{1, 2048, 4095, 0, 300};
		idles = '{30, 0, 50, 20, 0};
		held = 1'b0;
		paused = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		row_valid = 1'b0;
		row = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed rows under the reset display size
		idle_pct = 20;
		offer(make_row(QUAD_UPPER_RIGHT, 100, 100, 20, 50, 0, 0, 60, 0, 0));
		offer(make_row(QUAD_UPPER_RIGHT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		offer(make_row(QUAD_UPPER_LEFT, 2047, 2047, 511, 511, SLOPE_FULL, SLOPE_FULL,
			511, 1, 1));
		for (int q = 0; q < 4; q++) begin
			if (q == QUAD_UPPER_RIGHT || q == QUAD_LOWER_LEFT) begin
				offer(make_row(2'(q), 1000, 1000, 100, 200, 0, SLOPE_FULL, 50, 0, 0));
				offer(make_row(2'(q), 1000, 1000, 100, 200, 'h8000, 'h2_0000, 80, 1, q == 0));
			end else begin
				offer(make_row(2'(q), 1000, 1000, 100, 200, SLOPE_FULL, 0, 50, 0, 0));
				offer(make_row(2'(q), 1000, 1000, 100, 200, 'h2_0000, 'h8000, 80, 1, 0));
			end
		end
		offer(make_row(QUAD_UPPER_RIGHT, 500, 500, 10, 100, 0, SLOPE_FULL, 20, 0, 0));
		offer(make_row(QUAD_UPPER_RIGHT, 2047, 100, 0, 511, 0, SLOPE_FULL, 0, 0, 0));
		offer(make_row(QUAD_LOWER_RIGHT, 10, 2047, 0, 511, SLOPE_FULL, 0, 511, 0, 0));
		offer(make_row(QUAD_LOWER_LEFT, 0, 300, 0, 300, 0, SLOPE_FULL, 10, 0, 0));
		offer(make_row(QUAD_UPPER_LEFT, 0, 0, 0, 300, SLOPE_FULL, 0, 200, 1, 0));
		offer(make_row(QUAD_UPPER_RIGHT, 700, 700, 50, 200, SLOPE_FULL, 0, 100, 0, 0));
		offer(make_row(QUAD_LOWER_RIGHT, 1500, 1500, 30, 60, SLOPE_FULL, 0, 5, 1, 1));
		offer(make_row(QUAD_LOWER_LEFT, 40, 40, 3, 3, 0, SLOPE_FULL, 1, 0, 1));
		offer(make_row(QUAD_UPPER_RIGHT, 800, 800, 200, 511, 'h1_0000, 'h1_0000, 511, 1, 0));

		// zero display size, then the unused register slots
		drain();
		set_dims(0, 0);
		write_reg(REG_SPARE_A, DIM_BITS'($urandom));
		write_reg(REG_SPARE_B, '1);
		offer(make_row(QUAD_UPPER_RIGHT, 20, 20, 0, 5, 0, SLOPE_FULL, 0, 0, 1));
		offer(make_row(QUAD_LOWER_LEFT, 20, 20, 0, 5, 0, SLOPE_FULL, 2, 1, 1));
		offer(make_row(QUAD_UPPER_LEFT, 20, 20, 0, 5, SLOPE_FULL, 0, 3, 1, 0));

		for (int p = 0; p < 5; p++) begin
			drain();
			if (p == 3) begin
				set_dims(DIM_BITS'($urandom_range(1, 2048)), DIM_BITS'($urandom_range(1, 2048)));
				write_reg(REG_SPARE_A, DIM_BITS'($urandom));
			end else begin
				set_dims(DIM_BITS'(widths[p]), DIM_BITS'(heights[p]));
			end
			idle_pct = idles[p];
			goal = sent + 120;
			while (sent < goal) begin
				if ($urandom_range(4) == 0) begin
					offer(noise_row());
				end else begin
					sweep_sector();
				end
				if (p == 2 && !held && sent >= goal - 60) begin
					hold_cycles = 400;
					held = 1'b1;
				end
				if (p == 3 && !paused && sent >= goal - 60) begin
					drain();
					paused = 1'b1;
				end
			end
		end

		drain();
		repeat (60) @(negedge clk);
		if (fails == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
